### design/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and constants of the message aggregation block.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

    localparam int HND_W      = 3;
    localparam int TGT_W      = 4;
    localparam int CNT_W      = 5;
    localparam int SLOT_W     = HND_W + TGT_W;
    localparam int WSEL_W     = 4;
    localparam int WADDR_W    = SLOT_W + WSEL_W;
    localparam int WORD_W     = 64;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int WORDS      = 1 << WADDR_W;
    localparam int HANDLERS   = 1 << HND_W;
    localparam int TARGETS    = 1 << TGT_W;
    localparam int CAP_WORDS  = 1 << WSEL_W;
    localparam int RES_LIMIT  = 16;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } cnt_wr_t;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } word_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_second;
        logic [WORD_W-1:0] word_first;
        logic [CNT_W-1:0]  batch_count;
        logic [TGT_W-1:0]  out_target;
        logic [HND_W-1:0]  out_handler;
        logic              batch_start;
    } result_t;

endpackage

`default_nettype wire

### design/maf_cnt_mem.sv
// ----------------------------------------------------------------------------
// maf_cnt_mem
// Per-slot entry counts: synchronous memory with valid bits, unwritten reads 0.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_cnt_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire maf_pkg::cnt_wr_t          wr,
    input  wire logic [maf_pkg::SLOT_W-1:0] raddr,
    output logic [maf_pkg::CNT_W-1:0]      rdata
);

    logic [maf_pkg::CNT_W-1:0] mem [maf_pkg::SLOTS];
    logic [maf_pkg::SLOTS-1:0] vld_reg;
    logic [maf_pkg::CNT_W-1:0] rd_reg;
    logic                      rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

### design/maf_word_mem.sv
// ----------------------------------------------------------------------------
// maf_word_mem
// Buffered argument words, one row of capacity words per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_word_mem (
    input  wire logic                       clk,
    input  wire maf_pkg::word_wr_t          wr,
    input  wire logic [maf_pkg::WADDR_W-1:0] raddr,
    output logic [maf_pkg::WORD_W-1:0]      rdata
);

    logic [maf_pkg::WORD_W-1:0] mem [maf_pkg::WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/message_aggregation_flush_policy.sv
// ----------------------------------------------------------------------------
// message_aggregation_flush_policy
// Coalesces messages per handler and target and emits them in batches.
// ----------------------------------------------------------------------------
// Input words (s_*) carry an enqueue or a flush command; tuser is the command.
// An enqueue stores one entry and may evict the fullest target of its handler;
// a flush emits every nonempty target of the handler below num_places in
// target order; a command emits at most 16 entries. Every emitted entry is
// one output word (m_*); tlast marks the last word of a command, tuser marks
// the first entry of a batch. Timing: s_tready is high only between commands.
// An enqueue writes its first word in its count step and, with two words per
// entry, its second in a further write step. A scan reads and then checks
// each target in use (registered count memory read); each emitted entry takes
// read steps on the one word memory port, one more with two words per entry,
// then a put step, plus a clear step per batch and a finish step per command.
// One output word trails in a holding stage so tlast can be set.
// A stalled receiver holds the engine in its emit step; nothing is lost.
// Reset clears counts (valid bits), totals and config (16 places, 1 word).
// Config registers: 0x0 num_places, 0x4 words_per_entry; write while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module message_aggregation_flush_policy (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // handler[2:0], target[6:3], arg_first[70:7], arg_second[134:71]
    input  wire logic [135:0] s_tdata,
    // cmd[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_handler[2:0], out_target[6:3], batch_count[11:7],
    // word_first[75:12], word_second[139:76]
    output logic [143:0]      m_tdata,
    // batch_start[0]
    output logic              m_tuser,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CNT  = 4'd1;
    localparam logic [3:0] ST_WR2  = 4'd2;
    localparam logic [3:0] ST_SRD  = 4'd3;
    localparam logic [3:0] ST_SCK  = 4'd4;
    localparam logic [3:0] ST_EMA  = 4'd5;
    localparam logic [3:0] ST_EMB  = 4'd6;
    localparam logic [3:0] ST_EMC  = 4'd7;
    localparam logic [3:0] ST_PUT  = 4'd8;
    localparam logic [3:0] ST_CLR  = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    localparam int CW = maf_pkg::CNT_W;
    localparam int TW = maf_pkg::TGT_W;
    localparam int HW = maf_pkg::HND_W;

    logic [3:0]    state_reg, state_next;
    logic [HW-1:0] h_reg, h_next;
    logic          flush_reg, flush_next;
    logic          evict_reg, evict_next;
    logic [63:0]   arg1_reg, arg1_next, arg2_reg, arg2_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [TW-1:0] best_reg, best_next, emt_reg, emt_next;
    logic [CW-1:0] bestcnt_reg, bestcnt_next, emcnt_reg, emcnt_next;
    logic [CW-1:0] k_reg, k_next, n_reg, n_next;
    logic [63:0]   w1_reg, w1_next, w2_reg, w2_next;
    logic          pend_valid_reg, pend_valid_next;
    maf_pkg::result_t pend_reg, pend_next, out_reg, out_next;
    logic          out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [CW-1:0] totals_reg [maf_pkg::HANDLERS];
    logic [CW-1:0] totals_next [maf_pkg::HANDLERS];
    logic [CW-1:0] places_reg;
    logic [1:0]    wpe_reg;

    maf_pkg::cnt_wr_t  cnt_wr;
    maf_pkg::word_wr_t word_wr;
    logic [maf_pkg::SLOT_W-1:0]  cnt_raddr;
    logic [CW-1:0]               cnt_rd;
    logic [maf_pkg::WADDR_W-1:0] word_raddr;
    logic [63:0]                 word_rd;

    logic [HW-1:0] in_h;
    logic [TW-1:0] in_t;
    logic [CW-1:0] places;
    logic          wpe2;
    logic          out_free;
    logic          cfg_wr;
    logic [5:0]    a_k, a_cnt, a_cntr;
    logic [CW-1:0] tot_inc, idx_inc, nb;
    logic [5:0]    tot_p1;
    logic          last_tgt, upd;
    logic [TW-1:0] nbest;
    maf_pkg::result_t new_res;

    assign in_h     = s_tdata[2:0];
    assign in_t     = s_tdata[6:3];
    assign places   = (places_reg > CW'(maf_pkg::TARGETS)) ? CW'(maf_pkg::TARGETS)
                                                          : places_reg;
    assign wpe2     = wpe_reg[1];
    assign out_free = !out_valid_reg || m_tready;
    assign a_k      = {1'b0, k_reg} << wpe2;
    assign a_cnt    = {1'b0, cnt_rd} << wpe2;
    assign a_cntr   = ({1'b0, cnt_reg} << wpe2) + 6'd1;
    assign tot_inc  = totals_reg[h_reg] + CW'(1);
    assign tot_p1   = {1'b0, tot_inc} + 6'd1;
    assign idx_inc  = idx_reg + CW'(1);
    assign last_tgt = idx_inc >= places;
    assign upd      = cnt_rd > bestcnt_reg;
    assign nb       = upd ? cnt_rd : bestcnt_reg;
    assign nbest    = upd ? idx_reg[TW-1:0] : best_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {30'd0, wpe_reg} : {27'd0, places_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            places_reg <= CW'(16);
            wpe_reg    <= 2'd1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                wpe_reg <= pwdata[1:0];
            end
            else
            begin
                places_reg <= pwdata[CW-1:0];
            end
        end
    end

    maf_cnt_mem u_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cnt_wr),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    maf_word_mem u_word (
        .clk   (clk),
        .wr    (word_wr),
        .raddr (word_raddr),
        .rdata (word_rd)
    );

    assign cnt_raddr  = (state_reg == ST_IDLE) ? {in_h, in_t} : {h_reg, idx_reg[TW-1:0]};
    assign word_raddr = (state_reg == ST_EMB) ? {h_reg, emt_reg, a_k[3:0] | 4'd1}
                                              : {h_reg, emt_reg, a_k[3:0]};

    always_comb
    begin
        new_res.word_second = w2_reg;
        new_res.word_first  = w1_reg;
        new_res.batch_count = emcnt_reg;
        new_res.out_target  = emt_reg;
        new_res.out_handler = h_reg;
        new_res.batch_start = (k_reg == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        h_next          = h_reg;
        flush_next      = flush_reg;
        evict_next      = evict_reg;
        arg1_next       = arg1_reg;
        arg2_next       = arg2_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        bestcnt_next    = bestcnt_reg;
        emt_next        = emt_reg;
        emcnt_next      = emcnt_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        totals_next     = totals_reg;
        cnt_wr.we       = 1'b0;
        cnt_wr.addr     = {h_reg, emt_reg};
        cnt_wr.data     = '0;
        word_wr.we      = 1'b0;
        word_wr.addr    = {h_reg, emt_reg, a_cntr[3:0]};
        word_wr.data    = arg2_reg;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    h_next       = in_h;
                    emt_next     = in_t;
                    flush_next   = s_tuser;
                    arg1_next    = s_tdata[70:7];
                    arg2_next    = s_tdata[134:71];
                    idx_next     = '0;
                    n_next       = '0;
                    best_next    = '0;
                    bestcnt_next = '0;
                    if (s_tuser)
                    begin
                        state_next = (places == '0) ? ST_IDLE : ST_SRD;
                    end
                    else
                    begin
                        state_next = ({1'b0, in_t} >= places) ? ST_IDLE : ST_CNT;
                    end
                end
            end
            ST_CNT:
            begin
                cnt_next     = cnt_rd;
                word_wr.we   = (a_cnt < 6'(maf_pkg::CAP_WORDS));
                word_wr.addr = {h_reg, emt_reg, a_cnt[3:0]};
                word_wr.data = arg1_reg;
                cnt_wr.we    = 1'b1;
                cnt_wr.data  = cnt_rd + CW'(1);
                totals_next[h_reg] = tot_inc;
                evict_next   = wpe2 ? (tot_p1 >= 6'(maf_pkg::CAP_WORDS / 2))
                                    : (tot_p1 >= 6'(maf_pkg::CAP_WORDS));
                if (wpe2)
                begin
                    state_next = ST_WR2;
                end
                else
                begin
                    state_next = evict_next ? ST_SRD : ST_IDLE;
                end
            end
            ST_WR2:
            begin
                word_wr.we = (a_cntr < 6'(maf_pkg::CAP_WORDS));
                state_next = evict_reg ? ST_SRD : ST_IDLE;
            end
            ST_SRD:
            begin
                state_next = ST_SCK;
            end
            ST_SCK:
            begin
                if (flush_reg)
                begin
                    if (cnt_rd != '0)
                    begin
                        emt_next   = idx_reg[TW-1:0];
                        emcnt_next = cnt_rd;
                        k_next     = '0;
                        state_next = ST_EMA;
                    end
                    else if (last_tgt)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    best_next    = nbest;
                    bestcnt_next = nb;
                    if (!last_tgt)
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_SRD;
                    end
                    else if (nb != '0)
                    begin
                        emt_next   = nbest;
                        emcnt_next = nb;
                        k_next     = '0;
                        state_next = ST_EMA;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_EMA:
            begin
                // stop at the batch end or at the per-command result limit
                if ((k_reg >= emcnt_reg) || (n_reg == CW'(maf_pkg::RES_LIMIT)))
                begin
                    state_next = ST_CLR;
                end
                else
                begin
                    state_next = ST_EMB;
                end
            end
            ST_EMB:
            begin
                w1_next = (a_k < 6'(maf_pkg::CAP_WORDS)) ? word_rd : '0;
                if (wpe2)
                begin
                    state_next = ST_EMC;
                end
                else
                begin
                    w2_next    = '0;
                    state_next = ST_PUT;
                end
            end
            ST_EMC:
            begin
                w2_next    = ((a_k + 6'd1) < 6'(maf_pkg::CAP_WORDS)) ? word_rd : '0;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                    k_next          = k_reg + CW'(1);
                    n_next          = n_reg + CW'(1);
                    state_next      = ST_EMA;
                end
            end
            ST_CLR:
            begin
                cnt_wr.we          = 1'b1;
                totals_next[h_reg] = totals_reg[h_reg] - emcnt_reg;
                if (flush_reg && !last_tgt)
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // release the held word with tlast
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            for (int i = 0; i < maf_pkg::HANDLERS; i++)
            begin
                totals_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            totals_reg     <= totals_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg       <= h_next;
        flush_reg   <= flush_next;
        evict_reg   <= evict_next;
        arg1_reg    <= arg1_next;
        arg2_reg    <= arg2_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        bestcnt_reg <= bestcnt_next;
        emt_reg     <= emt_next;
        emcnt_reg   <= emcnt_next;
        k_reg       <= k_next;
        w1_reg      <= w1_next;
        w2_reg      <= w2_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.word_second, out_reg.word_first, out_reg.batch_count,
                       out_reg.out_target, out_reg.out_handler};
    assign m_tuser  = out_reg.batch_start;
    assign m_tlast  = out_last_reg;

    a_put_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT && !out_free) |=> (state_reg == ST_PUT))
        else $error("emit step left while output stalled");

    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(maf_pkg::RES_LIMIT))
        else $error("result count beyond limit");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !pend_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("finish without held word did not return to idle");

    a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!cnt_wr.we && !word_wr.we))
        else $error("memory write while accepting");

endmodule

`default_nettype wire

### test/tb_message_aggregation_flush_policy.sv
// ----------------------------------------------------------------------------
// tb_message_aggregation_flush_policy
// Self-checking bench: drives enqueue and flush commands under several
// register settings, predicts every emitted batch word and checks the output
// stream field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_message_aggregation_flush_policy;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_PLACES = 3'd0;
    localparam logic [2:0] ADDR_WPE    = 3'd4;
    localparam bit         CMD_ENQ     = 1'b0;
    localparam bit         CMD_FLUSH   = 1'b1;
    localparam int         HOLD_LEN    = 400;
    localparam int         SETTLE      = 120;

    typedef struct {
        bit        cmd;
        bit [2:0]  hnd;
        bit [3:0]  tgt;
        bit [63:0] arg1;
        bit [63:0] arg2;
    } msg_t;

    typedef struct packed {
        bit [2:0]  hnd;
        bit [3:0]  tgt;
        bit [4:0]  cnt;
        bit [63:0] w1;
        bit [63:0] w2;
        bit        start;
        bit        last;
    } batch_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // handler[2:0], target[6:3], arg_first[70:7], arg_second[134:71]
    logic         s_tuser;   // cmd[0]
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;   // out_handler[2:0], out_target[6:3], batch_count[11:7],
                             // word_first[75:12], word_second[139:76]
    logic         m_tuser;   // batch_start[0]
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    message_aggregation_flush_policy dut (.*);

    // shadow of the block
    bit [4:0]  counts [maf_pkg::HANDLERS][maf_pkg::TARGETS];
    bit [4:0]  totals [maf_pkg::HANDLERS];
    bit [63:0] words  [maf_pkg::HANDLERS][maf_pkg::TARGETS][maf_pkg::CAP_WORDS];
    bit [4:0]  places_reg;
    bit [1:0]  wpe_reg;

    msg_t        send_q[$];
    batch_word_t batch_q[$];
    msg_t        cur_msg;
    int          errors;
    bit          calm;
    bit          rx_hold_go;
    int          rx_hold_cnt;
    int          tx_gap;
    int          rx_gap;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit [63:0] read_word(int h, int t, int w);
        if (w >= maf_pkg::CAP_WORDS)
            return 64'd0;
        return words[h][t][w];
    endfunction

    function automatic void emit_batch(int h, int t, int wpe, ref batch_word_t res[$]);
        batch_word_t bw;
        int cnt;
        cnt = counts[h][t];
        for (int k = 0; k < cnt && res.size() < maf_pkg::RES_LIMIT; k++)
        begin
            bw.hnd   = h;
            bw.tgt   = t;
            bw.cnt   = cnt;
            bw.w1    = read_word(h, t, k * wpe);
            bw.w2    = (wpe == 2) ? read_word(h, t, k * wpe + 1) : 64'd0;
            bw.start = (k == 0);
            bw.last  = 1'b0;
            res.push_back(bw);
        end
        totals[h]    = totals[h] - cnt;
        counts[h][t] = 5'd0;
    endfunction

    function automatic void aggregate(msg_t m);
        batch_word_t res[$];
        int places;
        int wpe;
        int best;
        int bestcnt;
        places = (places_reg > maf_pkg::TARGETS) ? maf_pkg::TARGETS : places_reg;
        wpe    = (wpe_reg == 2'd0) ? 1 : (wpe_reg == 2'd3) ? 2 : wpe_reg;
        if (m.cmd == CMD_FLUSH)
        begin
            for (int i = 0; i < places; i++)
                if (counts[m.hnd][i] != 0)
                    emit_batch(m.hnd, i, wpe, res);
        end
        else if (m.tgt < places)
        begin
            if (counts[m.hnd][m.tgt] * wpe < maf_pkg::CAP_WORDS)
                words[m.hnd][m.tgt][counts[m.hnd][m.tgt] * wpe] = m.arg1;
            if (wpe == 2 && counts[m.hnd][m.tgt] * 2 + 1 < maf_pkg::CAP_WORDS)
                words[m.hnd][m.tgt][counts[m.hnd][m.tgt] * 2 + 1] = m.arg2;
            counts[m.hnd][m.tgt] = counts[m.hnd][m.tgt] + 1;
            totals[m.hnd]        = totals[m.hnd] + 1;
            if ((int'(totals[m.hnd]) + 1) * wpe >= maf_pkg::CAP_WORDS)
            begin
                best    = 0;
                bestcnt = 0;
                for (int i = 0; i < places; i++)
                    if (counts[m.hnd][i] > bestcnt)
                    begin
                        bestcnt = counts[m.hnd][i];
                        best    = i;
                    end
                if (bestcnt != 0)
                    emit_batch(m.hnd, best, wpe, res);
            end
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            batch_q.push_back(res[i]);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                aggregate(cur_msg);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= $urandom_range(0, 8);
                end
                else if (send_q.size() > 0)
                begin
                    cur_msg  = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_msg.cmd;
                    s_tdata  <= {1'b0, cur_msg.arg2, cur_msg.arg1, cur_msg.tgt, cur_msg.hnd};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rx_hold_go && rx_hold_cnt < HOLD_LEN)
            rx_hold_cnt <= rx_hold_cnt + 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        batch_word_t exp_w;
        batch_word_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.hnd   = m_tdata[2:0];
                got.tgt   = m_tdata[6:3];
                got.cnt   = m_tdata[11:7];
                got.w1    = m_tdata[75:12];
                got.w2    = m_tdata[139:76];
                got.start = m_tuser;
                got.last  = m_tlast;
                if (batch_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word h=%0d t=%0d", $time, got.hnd, got.tgt);
                end
                else
                begin
                    exp_w = batch_q.pop_front();
                    if (got != exp_w)
                    begin
                        errors++;
                        $display("%0t: mismatch expected h=%0d t=%0d n=%0d w1=%h w2=%h s=%0d l=%0d",
                                 $time, exp_w.hnd, exp_w.tgt, exp_w.cnt, exp_w.w1, exp_w.w2,
                                 exp_w.start, exp_w.last);
                        $display("%0t:          actual   h=%0d t=%0d n=%0d w1=%h w2=%h s=%0d l=%0d",
                                 $time, got.hnd, got.tgt, got.cnt, got.w1, got.w2,
                                 got.start, got.last);
                    end
                end
            end
            if (rx_hold_go && rx_hold_cnt < HOLD_LEN)
                m_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                rx_gap   <= $urandom_range(0, 8);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic drain();
        do
            @(posedge clk);
        while (send_q.size() > 0 || s_tvalid || batch_q.size() > 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PLACES)
            places_reg = value[4:0];
        else
            wpe_reg = value[1:0];
    endtask

    function automatic msg_t make_msg(bit cmd, int h, int t);
        msg_t m;
        m.cmd  = cmd;
        m.hnd  = h;
        m.tgt  = t;
        m.arg1 = {$urandom, $urandom};
        m.arg2 = {$urandom, $urandom};
        return m;
    endfunction

    function automatic void queue_random(int n, int tmax);
        for (int i = 0; i < n; i++)
            send_q.push_back(make_msg(($urandom_range(0, 11) == 0) ? CMD_FLUSH : CMD_ENQ,
                                      $urandom_range(0, 2) == 0 ? $urandom_range(0, 7)
                                                                : $urandom_range(0, 1),
                                      $urandom_range(0, tmax)));
    endfunction

    // switch words per entry only with every handler empty, so no stale slot is read
    task automatic set_config(bit [4:0] places, bit [1:0] wpe);
        drain();
        if (((wpe_reg == 0) ? 1 : (wpe_reg == 3) ? 2 : wpe_reg)
            != ((wpe == 0) ? 1 : (wpe == 3) ? 2 : wpe))
        begin
            reg_write(ADDR_PLACES, 32'd16);
            for (int h = 0; h < maf_pkg::HANDLERS; h++)
                send_q.push_back(make_msg(CMD_FLUSH, h, 0));
            drain();
        end
        reg_write(ADDR_WPE, {30'd0, wpe});
        reg_write(ADDR_PLACES, {27'd0, places});
    endtask

    initial
    begin
        msg_t m;
        errors      = 0;
        calm        = 1'b0;
        rx_hold_go  = 1'b0;
        rx_hold_cnt = 0;
        places_reg  = 5'd16;
        wpe_reg     = 2'd1;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, empty flush, tie on eviction, flush order
        send_q.push_back(make_msg(CMD_FLUSH, 7, 0));
        m = make_msg(CMD_ENQ, 0, 0);
        m.arg1 = '1;
        m.arg2 = '1;
        send_q.push_back(m);
        m = make_msg(CMD_ENQ, 7, 15);
        m.arg1 = '0;
        m.arg2 = '0;
        send_q.push_back(m);
        send_q.push_back(make_msg(CMD_FLUSH, 7, 15));
        send_q.push_back(make_msg(CMD_FLUSH, 0, 0));
        for (int i = 0; i < 15; i++)
            send_q.push_back(make_msg(CMD_ENQ, 3, (i % 3 == 2) ? 9 : i % 2 ? 4 : 11));
        send_q.push_back(make_msg(CMD_FLUSH, 3, 0));
        drain();

        // receiver holds off while the sender keeps feeding
        queue_random(50, 15);
        rx_hold_go <= 1'b1;

        set_config(5'd16, 2'd2);
        queue_random(50, 15);
        set_config(5'd12, 2'd2);
        queue_random(40, 15);
        set_config(5'd4, 2'd2);     // stale targets from four up stay counted
        queue_random(40, 7);
        set_config(5'd1, 2'd1);
        queue_random(50, 2);
        set_config(5'd0, 2'd0);
        queue_random(15, 15);
        set_config(5'd31, 2'd3);
        queue_random(50, 15);
        set_config(5'd20, 2'd0);
        queue_random(50, 15);
        set_config(5'd7, 2'd1);
        queue_random(50, 15);
        set_config(5'd16, 2'd1);
        calm = 1'b1;
        queue_random(60, 15);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
